>>> hw/rtl/htwd_pkg.sv
// Package for the Huffman tree-walk decoder: transfer structs, node table entry,
// mode and result codes. No dependencies.
package htwd_pkg;

  localparam int NODE_SLOTS = 512;
  localparam int NODE_AW    = $clog2(NODE_SLOTS);

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;
  localparam logic [1:0] MODE_END   = 2'd3;

  localparam logic [1:0] KIND_SYM   = 2'd0;
  localparam logic [1:0] KIND_EOD   = 2'd1;
  localparam logic [1:0] KIND_PATH  = 2'd2;
  localparam logic [1:0] KIND_DEGEN = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  node_index;
    logic        node_is_leaf;
    logic [7:0]  node_symbol;
    logic [8:0]  left_child;
    logic [8:0]  right_child;
    logic        left_present;
    logic        right_present;
    logic [7:0]  data_byte;
    logic [63:0] symbol_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
    logic       block_done;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       leaf;
    logic [7:0] sym;
    logic [8:0] left;
    logic [8:0] right;
    logic       left_present;
    logic       right_present;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage

>>> hw/rtl/htwd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module htwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/huffman_tree_walk_decoder_core.sv
// Load items write the node table and stay idle; start and end items may pass through
// ST_START or ST_EOD. A data byte walks each bit through ST_STEP and ST_CHILD, since
// each bit needs a dependent read of the node table; ST_FLUSH releases a held result.
// A symbol is held back until the next result or the end of the byte shows whether it
// is the last; a stalled output holds back the next result. Reset clears the control state
// and the root register; the node table is not cleared. Depends on htwd_pkg, htwd_ram.
module huffman_tree_walk_decoder_core
  import htwd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [8:0] cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_CHILD = 3'd3;
  localparam logic [2:0] ST_EOD   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [8:0]       root_q;
  logic [8:0]       walk_q, walk_d;
  logic [63:0]      cnt_q, cnt_d;
  logic             active_q, active_d;
  logic [7:0]       byte_q, byte_d;
  logic [2:0]       bit_q, bit_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;
  logic             pend_valid_q, pend_valid_d;
  out_item_t        pend_q, pend_d;

  logic             ram_we, ram_re;
  logic [NODE_AW-1:0] ram_raddr;
  logic [NODE_W-1:0] ram_rdata;
  node_t            node, wnode;
  logic             out_free, emit, sel_bit, child_ok;
  out_item_t        emit_item;
  logic [8:0]       child_idx;
  out_item_t        sym_item;
  logic             sym_final, sym_take;

  assign wnode = '{leaf: in_data_i.node_is_leaf, sym: in_data_i.node_symbol,
                   left: in_data_i.left_child, right: in_data_i.right_child,
                   left_present: in_data_i.left_present,
                   right_present: in_data_i.right_present};

  htwd_ram #(.Width(NODE_W), .Depth(NODE_SLOTS)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_data_i.node_index),
    .wdata_i (wnode),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign node      = ram_rdata;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign sel_bit   = byte_q[bit_q];
  assign child_idx = sel_bit ? node.right : node.left;
  assign child_ok  = sel_bit ? node.right_present : node.left_present;
  assign sym_item  = '{kind: KIND_SYM, symbol: node.sym, block_done: (cnt_q == 64'd1),
                       last: 1'b0};
  assign sym_final = (cnt_q == 64'd1) || (bit_q == 3'd0);

  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    cnt_d        = cnt_q;
    active_d     = active_q;
    byte_d       = byte_q;
    bit_d        = bit_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = walk_q;
    emit         = 1'b0;
    emit_item    = '0;
    sym_take     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.mode)
            MODE_LOAD: begin
              ram_we = 1'b1;
            end
            MODE_START: begin
              cnt_d    = in_data_i.symbol_count;
              walk_d   = root_q;
              active_d = 1'b0;
              if (in_data_i.symbol_count != 64'd0) begin
                ram_re    = 1'b1;
                ram_raddr = root_q;
                state_d   = ST_START;
              end
            end
            MODE_DATA: begin
              if (active_q) begin
                byte_d  = in_data_i.data_byte;
                bit_d   = 3'd7;
                ram_re  = 1'b1;
                state_d = ST_STEP;
              end
            end
            MODE_END: begin
              if (active_q && cnt_q != 64'd0) begin
                state_d = ST_EOD;
              end
            end
          endcase
        end
      end
      ST_START: begin
        if (node.leaf) begin
          if (out_free) begin
            emit           = 1'b1;
            emit_item.kind = KIND_DEGEN;
            emit_item.last = 1'b1;
            state_d        = ST_IDLE;
          end
        end else begin
          active_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_STEP: begin
        if (node.leaf || !child_ok) begin
          if (out_free) begin
            emit     = 1'b1;
            active_d = 1'b0;
            if (pend_valid_q) begin
              emit_item   = pend_q;
              pend_d      = '0;
              pend_d.kind = node.leaf ? KIND_DEGEN : KIND_PATH;
              state_d     = ST_FLUSH;
            end else begin
              emit_item.kind = node.leaf ? KIND_DEGEN : KIND_PATH;
              emit_item.last = 1'b1;
              state_d        = ST_IDLE;
            end
          end
        end else begin
          walk_d    = child_idx;
          ram_re    = 1'b1;
          ram_raddr = child_idx;
          state_d   = ST_CHILD;
        end
      end
      ST_CHILD: begin
        if (node.leaf) begin
          if (pend_valid_q || sym_final) begin
            if (out_free) begin
              emit     = 1'b1;
              sym_take = 1'b1;
              if (pend_valid_q) begin
                emit_item = pend_q;
                pend_d    = sym_item;
              end else begin
                emit_item      = sym_item;
                emit_item.last = 1'b1;
              end
            end
          end else begin
            sym_take     = 1'b1;
            pend_valid_d = 1'b1;
            pend_d       = sym_item;
          end
          if (sym_take) begin
            cnt_d = cnt_q - 64'd1;
            if (cnt_q == 64'd1) begin
              active_d = 1'b0;
              state_d  = pend_valid_q ? ST_FLUSH : ST_IDLE;
            end else begin
              walk_d = root_q;
              if (bit_q == 3'd0) begin
                state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
              end else begin
                bit_d     = bit_q - 3'd1;
                ram_re    = 1'b1;
                ram_raddr = root_q;
                state_d   = ST_STEP;
              end
            end
          end
        end else if (bit_q == 3'd0) begin
          state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
        end else begin
          bit_d   = bit_q - 3'd1;
          state_d = ST_STEP;
        end
      end
      ST_EOD: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_item.kind = KIND_EOD;
          emit_item.last = 1'b1;
          active_d       = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_item      = pend_q;
          emit_item.last = 1'b1;
          pend_valid_d   = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_d = out_data_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = emit_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      root_q       <= '0;
      walk_q       <= '0;
      cnt_q        <= '0;
      active_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      cnt_q        <= cnt_d;
      active_q     <= active_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    bit_q      <= bit_d;
    out_data_q <= out_data_d;
    pend_q     <= pend_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hw/rtl/htwd_checker.sv
// Port-level checks for the Huffman tree-walk decoder, bound to the top level.
// Depends on htwd_pkg.
module htwd_checker
  import htwd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled result transfer changed.");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_SYM |->
      out_data_o.last && out_data_o.symbol == 8'd0 && !out_data_o.block_done)
    else $error("Error result is not a clean final result.");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.block_done |->
      out_data_o.last && out_data_o.kind == KIND_SYM)
    else $error("Block completion is not a final symbol result.");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode == MODE_LOAD |=> !in_stall_o)
    else $error("Node load did not complete in one cycle.");

endmodule

bind huffman_tree_walk_decoder_core htwd_checker u_htwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
